>>> rtl/cut_pkg.sv
// ---------------------------------------------------------------------------
// cut_pkg
// shared types and constants of the credential uid table
// ---------------------------------------------------------------------------
package cut_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SLOT_W      = 8;
    localparam int UID_W       = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    // result slot when nothing matched or was written
    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TABLE_SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_IDENTIFY = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_ADMIN    = 3'd2,
        CMD_DEL_ONE  = 3'd3,
        CMD_DEL_ALL  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [UID_W-1:0]  uid;
        logic [SLOT_W-1:0] idx;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

>>> rtl/cut_ram.sv
// ---------------------------------------------------------------------------
// cut_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module cut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/cut_ctrl.sv
// ---------------------------------------------------------------------------
// cut_ctrl
// command sequencer: slot scan over the uid ram, valid marks, table updates
// ---------------------------------------------------------------------------
module cut_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  cut_pkg::request_t           req,
    input  logic                        out_free,
    output logic                        res_valid,
    output cut_pkg::result_t            res,
    output logic                        ram_we,
    output logic [cut_pkg::IDX_W-1:0]   ram_waddr,
    output logic [cut_pkg::UID_W-1:0]   ram_wdata,
    output logic [cut_pkg::IDX_W-1:0]   ram_raddr,
    input  logic [cut_pkg::UID_W-1:0]   ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                                state_reg, state_next;
    cut_pkg::request_t                     req_reg;
    logic [cut_pkg::SLOT_W-1:0]            scan_cnt_reg;
    logic                                  rd_pend_reg;
    logic [cut_pkg::SLOT_W-1:0]            data_slot_reg;
    logic [cut_pkg::SLOT_W-1:0]            hit_slot_reg;
    logic [cut_pkg::SLOT_W-1:0]            empty_slot_reg;
    logic [cut_pkg::TABLE_SLOTS-1:0]       valid_reg;

    logic                                  issue;
    logic [cut_pkg::UID_W-1:0]             eff_uid;
    logic                                  del_ok;
    logic                                  set_valid;
    logic                                  clr_valid;
    logic                                  clr_all;
    logic [cut_pkg::IDX_W-1:0]             vaddr;

    assign req_ready = (state_reg == S_IDLE);
    assign issue     = (state_reg == S_SCAN) && (scan_cnt_reg < cut_pkg::SLOT_NONE);
    assign ram_raddr = scan_cnt_reg[cut_pkg::IDX_W-1:0];

    // an empty slot always reads as uid zero
    assign eff_uid = valid_reg[data_slot_reg[cut_pkg::IDX_W-1:0]] ? ram_rdata : '0;

    assign del_ok = (req_reg.idx < cut_pkg::SLOT_NONE)
                    && valid_reg[req_reg.idx[cut_pkg::IDX_W-1:0]];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    if (req.cmd == cut_pkg::CMD_IDENTIFY || req.cmd == cut_pkg::CMD_ADD) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (!issue && !rd_pend_reg) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        res_valid  = (state_reg == S_FINISH) && out_free;
        res.status = cut_pkg::ST_NOT_FOUND;
        res.slot   = cut_pkg::SLOT_NONE;
        ram_we     = 1'b0;
        ram_waddr  = empty_slot_reg[cut_pkg::IDX_W-1:0];
        ram_wdata  = req_reg.uid;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        clr_all    = 1'b0;
        vaddr      = empty_slot_reg[cut_pkg::IDX_W-1:0];
        case (req_reg.cmd)
            cut_pkg::CMD_IDENTIFY: begin
                if (hit_slot_reg != cut_pkg::SLOT_NONE) begin
                    res.status = cut_pkg::ST_OK;
                    res.slot   = hit_slot_reg;
                end
            end
            cut_pkg::CMD_ADD: begin
                if (empty_slot_reg == cut_pkg::SLOT_NONE) begin
                    res.status = cut_pkg::ST_FULL;
                end else if (hit_slot_reg != cut_pkg::SLOT_NONE) begin
                    res.status = cut_pkg::ST_EXISTS;
                    res.slot   = hit_slot_reg;
                end else begin
                    res.status = cut_pkg::ST_OK;
                    res.slot   = empty_slot_reg;
                    ram_we     = res_valid;
                    set_valid  = res_valid;
                end
            end
            cut_pkg::CMD_ADMIN: begin
                res.status = cut_pkg::ST_OK;
                res.slot   = '0;
                ram_waddr  = '0;
                vaddr      = '0;
                ram_we     = res_valid;
                set_valid  = res_valid;
            end
            cut_pkg::CMD_DEL_ONE: begin
                vaddr = req_reg.idx[cut_pkg::IDX_W-1:0];
                if (del_ok) begin
                    res.status = cut_pkg::ST_OK;
                    res.slot   = req_reg.idx;
                    clr_valid  = res_valid;
                end
            end
            cut_pkg::CMD_DEL_ALL: begin
                res.status = cut_pkg::ST_OK;
                clr_all    = res_valid;
            end
            default: begin
                res.status = cut_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            if (req_valid && req_ready) begin
                scan_cnt_reg <= '0;
            end else if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            // cleared slots only drop their mark; the ram word is masked on read
            if (clr_all) begin
                valid_reg <= '0;
            end else if (set_valid) begin
                valid_reg[vaddr] <= 1'b1;
            end else if (clr_valid) begin
                valid_reg[vaddr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_slot_reg <= scan_cnt_reg;
        if (req_valid && req_ready) begin
            req_reg        <= req;
            hit_slot_reg   <= cut_pkg::SLOT_NONE;
            empty_slot_reg <= cut_pkg::SLOT_NONE;
        end else if (rd_pend_reg) begin
            // keep the lowest match and the lowest empty slot
            if (hit_slot_reg == cut_pkg::SLOT_NONE && eff_uid == req_reg.uid) begin
                hit_slot_reg <= data_slot_reg;
            end
            if (empty_slot_reg == cut_pkg::SLOT_NONE
                && !valid_reg[data_slot_reg[cut_pkg::IDX_W-1:0]]) begin
                empty_slot_reg <= data_slot_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && req_ready |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_write_in_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == S_FINISH && out_free)
        else $error("uid ram written outside result hand-off");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> data_slot_reg < cut_pkg::SLOT_NONE)
        else $error("scan read beyond the table");

    a_result_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res.slot <= cut_pkg::SLOT_NONE)
        else $error("result slot out of range");

    a_delete_all_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && req_reg.cmd == cut_pkg::CMD_DEL_ALL |=> valid_reg == '0)
        else $error("valid marks survived delete all");
`endif

endmodule

>>> rtl/credential_uid_table_top.sv
// ---------------------------------------------------------------------------
// credential_uid_table_top
// identify and add scan every slot of the table before the result is given: one
// slot per cycle is read through the single read port of the uid ram
// admin add, delete one, delete all and unknown commands skip the slot scan
// one request at a time; a new one is taken while the last result waits
// reset clears all valid marks, no clearing pass is needed
// ---------------------------------------------------------------------------
module credential_uid_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd[2:0], card_uid[34:3], slot_index[42:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], result_slot[9:2], zero fill
);

    cut_pkg::request_t               req;
    cut_pkg::result_t                res;
    logic                            res_valid;
    logic                            out_free;
    logic                            ram_we;
    logic [cut_pkg::IDX_W-1:0]       ram_waddr;
    logic [cut_pkg::UID_W-1:0]       ram_wdata;
    logic [cut_pkg::IDX_W-1:0]       ram_raddr;
    logic [cut_pkg::UID_W-1:0]       ram_rdata;
    logic                            m_tvalid_reg;
    cut_pkg::result_t                m_res_reg;

    assign req.cmd = cut_pkg::cmd_t'(s_tdata[2:0]);
    assign req.uid = s_tdata[34:3];
    assign req.idx = s_tdata[42:35];

    assign out_free = !m_tvalid_reg || m_tready;

    cut_ram #(
        .WIDTH (cut_pkg::UID_W),
        .DEPTH (cut_pkg::TABLE_SLOTS)
    ) u_uid_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cut_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.slot, m_res_reg.status};

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// credential uid table testbench
// drives identify, add, admin add, delete and reserved requests into the table over
// the input stream and checks every result against a slot table kept here;
// the table is filled up to full in each phase, and the receiver is held off
// once for a long stretch so that the block backs up and stalls its input
// ---------------------------------------------------------------------------
module testbench;
    import cut_pkg::*;

    // codes the block does not define and must ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
    localparam int FILL_LEN  = TABLE_SLOTS + 24;
    localparam int MIX_LEN   = 163;
    localparam int HOLD_LEN  = 400;

    class uid_table_scoreboard;
        logic [UID_W-1:0] slot_uid [TABLE_SLOTS];
        bit               slot_valid [TABLE_SLOTS];
        result_t          expected_q [$];
        int               errors;

        function new();
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (slot_uid[s]) begin
                slot_uid[s]   = '0;
                slot_valid[s] = 1'b0;
            end
        endfunction

        function int lowest_match(logic [UID_W-1:0] uid);
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (slot_uid[s] == uid) return s;
            end
            return TABLE_SLOTS;
        endfunction

        // work out the result of an accepted request and update the table
        function void note_request(logic [CMD_W-1:0] cmd, logic [UID_W-1:0] uid,
                                   logic [SLOT_W-1:0] idx);
            result_t r;
            int      free_slot;
            int      hit;
            r.status = ST_NOT_FOUND;
            r.slot   = SLOT_NONE;
            case (cmd)
                CMD_IDENTIFY: begin
                    hit = lowest_match(uid);
                    if (hit < TABLE_SLOTS) begin
                        r.status = ST_OK;
                        r.slot   = SLOT_W'(hit);
                    end
                end
                CMD_ADD: begin
                    free_slot = TABLE_SLOTS;
                    for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
                        if (!slot_valid[s]) free_slot = s;
                    end
                    if (free_slot >= TABLE_SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        // empty slots hold zero and count as a match
                        hit = lowest_match(uid);
                        if (hit < TABLE_SLOTS) begin
                            r.status = ST_EXISTS;
                            r.slot   = SLOT_W'(hit);
                        end else begin
                            slot_uid[free_slot]   = uid;
                            slot_valid[free_slot] = 1'b1;
                            r.status = ST_OK;
                            r.slot   = SLOT_W'(free_slot);
                        end
                    end
                end
                CMD_ADMIN: begin
                    slot_uid[0]   = uid;
                    slot_valid[0] = 1'b1;
                    r.status = ST_OK;
                    r.slot   = '0;
                end
                CMD_DEL_ONE: begin
                    if (idx < TABLE_SLOTS && slot_valid[idx]) begin
                        slot_uid[idx]   = '0;
                        slot_valid[idx] = 1'b0;
                        r.status = ST_OK;
                        r.slot   = idx;
                    end
                end
                CMD_DEL_ALL: begin
                    clear_table();
                    r.status = ST_OK;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot);
            result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no request waiting: status %0d, result_slot %0d",
                       status, slot);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                errors++;
            end
            if (slot !== exp_r.slot) begin
                $error("result_slot: expected %0d, actual %0d", exp_r.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_off  = 1'b0;
    uid_table_scoreboard sb = new();

    credential_uid_table_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[1:0], m_tdata[9:2]);
        end
    end

    // entered and left at a falling edge; valid stays high between back-to-back requests
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [UID_W-1:0] uid,
                                input logic [SLOT_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {5'b0, idx, uid, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, uid, idx);
        @(negedge aclk);
    endtask

    task automatic hold_receiver();
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(negedge aclk);
        hold_off <= 1'b0;
    endtask

    task automatic send_mixed();
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [UID_W-1:0]  uid;
        logic [SLOT_W-1:0] idx;
        pick = $urandom_range(0, 99);
        uid  = $urandom();
        idx  = SLOT_W'($urandom());
        cmd  = CMD_IDENTIFY;
        if (pick < 30) begin
            cmd = CMD_ADD;
        end else if (pick < 38) begin
            cmd = CMD_ADD;
            uid = sb.slot_uid[$urandom_range(0, TABLE_SLOTS - 1)];
        end else if (pick < 53) begin
            uid = sb.slot_uid[$urandom_range(0, TABLE_SLOTS - 1)];
        end else if (pick < 60) begin
            if (pick < 58) uid = '0;
        end else if (pick < 63) begin
            cmd = CMD_ADMIN;
        end else if (pick < 80) begin
            cmd = CMD_DEL_ONE;
            idx = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        end else if (pick < 88) begin
            cmd = CMD_DEL_ONE;
        end else if (pick < 89) begin
            cmd = CMD_DEL_ALL;
        end else if (pick < 92) begin
            cmd = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
        end else if (pick < 96) begin
            cmd = CMD_ADD;
            uid = '0;
        end else begin
            cmd = CMD_ADMIN;
            uid = sb.slot_uid[$urandom_range(0, TABLE_SLOTS - 1)];
        end
        send_request(cmd, uid, idx);
    endtask

    // clear, fill past full with mostly fresh uids, then mixed traffic
    task automatic run_phase(input int snd_pct, input int rcv_pct, input bit pressure);
        send_idle = snd_pct;
        recv_idle = rcv_pct;
        send_request(CMD_DEL_ALL, $urandom(), SLOT_W'($urandom()));
        for (int n = 0; n < FILL_LEN; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_request(CMD_ADD, sb.slot_uid[$urandom_range(0, TABLE_SLOTS - 1)],
                             SLOT_W'($urandom()));
            end else begin
                send_request(CMD_ADD, $urandom(), SLOT_W'($urandom()));
            end
        end
        if (pressure) begin
            fork
                hold_receiver();
            join_none
        end
        repeat (MIX_LEN) send_mixed();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty slots match zero, admin overwrite, delete edge indexes
        send_request(CMD_IDENTIFY, 32'h0000_0000, 8'h00);
        send_request(CMD_ADD,      32'h0000_0000, 8'h00);
        send_request(CMD_ADD,      32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_ADD,      32'hFFFF_FFFF, 8'h00);
        send_request(CMD_IDENTIFY, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_IDENTIFY, 32'h1234_5678, 8'h00);
        send_request(CMD_ADD,      32'h0000_0001, 8'h00);
        send_request(CMD_ADMIN,    32'hA5A5_A5A5, 8'h00);
        send_request(CMD_IDENTIFY, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_ADMIN,    32'h0000_0000, 8'h00);
        send_request(CMD_ADD,      32'h0000_0000, 8'h00);
        send_request(CMD_DEL_ONE,  32'h0000_0000, 8'h00);
        send_request(CMD_DEL_ONE,  32'h0000_0000, 8'h00);
        send_request(CMD_DEL_ONE,  32'h0000_0000, 8'(TABLE_SLOTS - 1));
        send_request(CMD_DEL_ONE,  32'h0000_0000, SLOT_NONE);
        send_request(CMD_DEL_ONE,  32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_DEL_ONE,  32'h0000_0000, 8'h01);
        send_request(CMD_RSVD_FIRST,         $urandom(), SLOT_W'($urandom()));
        send_request(CMD_RSVD_FIRST + 3'd1,  $urandom(), SLOT_W'($urandom()));
        send_request(CMD_RSVD_LAST,          $urandom(), SLOT_W'($urandom()));
        send_request(CMD_DEL_ALL,  32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_IDENTIFY, 32'h0000_0001, 8'h00);
        send_request(CMD_ADD,      32'h8000_0000, 8'hFF);
        send_request(CMD_DEL_ALL,  32'h0000_0000, 8'h00);

        run_phase(22, 77, 1'b0);
        run_phase(77, 22, 1'b0);
        run_phase(0, 0, 1'b1);

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (TABLE_SLOTS + 8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // a correct run needs well under 2 ms
    initial begin
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
